// File: hdl/single_wire_bus_slave_assert.svh
// Assertion macros for the single-wire bus slave checker.
`ifndef SINGLE_WIRE_BUS_SLAVE_ASSERT_SVH
`define SINGLE_WIRE_BUS_SLAVE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define SWB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("single_wire_bus_slave: next-cycle check failed");

`define SWB_ASSERT_LATER(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("single_wire_bus_slave: two-cycle check failed");

`endif

// File: hdl/swb_pkg.sv
// Types, codes and per-slot functions of the single-wire bus slave.
package swb_pkg;

	typedef enum logic [10:0] {
		PH_IDLE       = 11'b000_0000_0001,
		PH_RECV       = 11'b000_0000_0010,
		PH_SEND_HIGH  = 11'b000_0000_0100,
		PH_SEND_LOW   = 11'b000_0000_1000,
		PH_SEND_CHECK = 11'b000_0001_0000,
		PH_ACK1       = 11'b000_0010_0000,
		PH_ACK2       = 11'b000_0100_0000,
		PH_NACK1      = 11'b000_1000_0000,
		PH_NACK2      = 11'b001_0000_0000,
		PH_READY      = 11'b010_0000_0000,
		PH_STALL      = 11'b100_0000_0000
	} phase_t;

	typedef enum logic [7:0] {
		PS_IDLE    = 8'b0000_0001,
		PS_RX_ADDR = 8'b0000_0010,
		PS_ENUM    = 8'b0000_0100,
		PS_RX_CMD  = 8'b0000_1000,
		PS_RD_ADDR = 8'b0001_0000,
		PS_RD_DATA = 8'b0010_0000,
		PS_WR_ADDR = 8'b0100_0000,
		PS_WR_DATA = 8'b1000_0000
	} proto_t;

	// flag bit positions
	localparam int F_MUTE    = 0;
	localparam int F_PARITY  = 1;
	localparam int F_ENUM    = 2;
	localparam int F_CHECK   = 3;
	localparam int F_SEND    = 4;
	localparam int F_IDLE    = 5;
	localparam int F_CLRMUTE = 6;

	localparam logic [7:0] CODE_ENUMERATE = 8'haa;
	localparam logic [7:0] CMD_READ       = 8'h01;
	localparam logic [7:0] CMD_WRITE      = 8'h02;
	localparam logic [7:0] MASK_MSB       = 8'h80;
	localparam logic [7:0] ADDR_NONE      = 8'hff;
	localparam logic [7:0] BYTE_BLANK     = 8'hff;

	typedef struct packed {
		phase_t      phase;
		proto_t      ps;
		logic [7:0]  shift;
		logic [7:0]  mask;
		logic [7:0]  ptr;
		logic [7:0]  addr;
		logic [6:0]  flags;
	} st_t;

	typedef struct packed {
		logic       drive_low_next;
		logic       bus_active;
		logic       enumerated;
		logic [7:0] bus_address;
	} res_t;

	function automatic logic mutable(phase_t p);
		return p == PH_SEND_HIGH || p == PH_SEND_LOW || p == PH_SEND_CHECK ||
			p == PH_ACK1 || p == PH_ACK2 || p == PH_NACK1 || p == PH_NACK2;
	endfunction

	function automatic st_t load_bit(st_t s);
		st_t r;
		logic v;
		r = s;
		v = (s.mask != 8'd0) ? |(s.shift & s.mask) : s.flags[F_PARITY];
		if (!v) begin
			r.phase = PH_SEND_LOW;
		end else begin
			r.phase = s.flags[F_CHECK] ? PH_SEND_CHECK : PH_SEND_HIGH;
			r.flags[F_PARITY] = ~s.flags[F_PARITY];
		end
		return r;
	endfunction

	function automatic st_t slot(st_t s, logic high);
		st_t r;
		logic muted;
		r = s;
		muted = s.flags[F_MUTE] && mutable(s.phase);
		case (s.phase)
			PH_RECV: begin
				if (high) begin
					r.shift = s.shift | s.mask;
					r.flags[F_PARITY] = ~s.flags[F_PARITY];
				end
				if (s.mask != 8'd0) begin
					r.mask = s.mask >> 1;
				end else if (r.flags[F_PARITY]) begin
					r.phase = PH_READY;
					r.flags[F_IDLE] = 1'b1;
				end else begin
					r.phase = PH_STALL;
				end
			end
			PH_SEND_HIGH, PH_SEND_LOW, PH_SEND_CHECK: begin
				if (s.phase == PH_SEND_CHECK && !muted && !high)
					r.flags[F_MUTE] = 1'b1;
				if (s.mask == 8'd0) begin
					r.phase = PH_STALL;
				end else begin
					r.mask = s.mask >> 1;
					r = load_bit(r);
				end
			end
			PH_ACK1: r.phase = PH_ACK2;
			PH_NACK1: r.phase = PH_NACK2;
			PH_ACK2, PH_NACK2: begin
				r.flags[F_PARITY] = 1'b0;
				r.mask = MASK_MSB;
				if (s.flags[F_CLRMUTE]) begin
					r.flags[F_MUTE] = 1'b0;
					r.flags[F_CLRMUTE] = 1'b0;
				end
				if (s.flags[F_IDLE]) begin
					r.phase = PH_IDLE;
				end else if (s.flags[F_SEND]) begin
					r = load_bit(r);
				end else begin
					r.phase = PH_RECV;
					r.shift = 8'd0;
				end
			end
			PH_READY: begin
				if (high)
					r.phase = s.flags[F_PARITY] ? PH_NACK1 : PH_ACK1;
			end
			PH_STALL: r.phase = PH_STALL;
			default: r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

	function automatic st_t next_send(st_t s, logic [7:0] rd);
		st_t r;
		r = s;
		if (!s.flags[F_MUTE] || s.flags[F_CLRMUTE])
			r.shift = rd;
		r.ptr = s.ptr + 8'd1;
		r.phase = PH_READY;
		return r;
	endfunction

	function automatic st_t byte_done(st_t s, logic [7:0] rd, logic [7:0] id_base,
		logic [7:0] id_end);
		st_t r;
		r = s;
		case (s.ps)
			PS_RX_ADDR: begin
				if (s.shift == CODE_ENUMERATE) begin
					r.ps = PS_ENUM;
					r.flags[F_CHECK] = 1'b1;
					r.flags[F_SEND] = 1'b1;
					r.flags[F_ENUM] = 1'b0;
					r.ptr = id_base;
					r.addr = 8'd0;
				end else if (s.flags[F_ENUM] && s.shift == s.addr) begin
					r.phase = PH_READY;
					r.ps = PS_RX_CMD;
				end else begin
					r.phase = PH_IDLE;
				end
			end
			PS_RX_CMD: begin
				if (s.shift == CMD_READ) begin
					r.ps = PS_RD_ADDR;
					r.phase = PH_READY;
				end else if (s.shift == CMD_WRITE) begin
					r.ps = PS_WR_ADDR;
					r.phase = PH_READY;
				end else begin
					r.phase = PH_IDLE;
				end
			end
			PS_RD_ADDR: begin
				r.ptr = s.shift;
				r.flags[F_SEND] = 1'b1;
				r.ps = PS_RD_DATA;
			end
			PS_WR_ADDR: begin
				r.ptr = s.shift;
				r.ps = PS_WR_DATA;
				r.phase = PH_READY;
			end
			PS_WR_DATA: begin
				r.ptr = s.ptr + 8'd1;
				r.phase = PH_READY;
			end
			PS_ENUM: begin
				if (s.ptr == id_end && !s.flags[F_MUTE]) begin
					r.ps = PS_IDLE;
					r.flags[F_IDLE] = 1'b1;
					r.flags[F_ENUM] = 1'b1;
					r.phase = PH_READY;
				end else begin
					if (s.ptr == id_end) begin
						r.ptr = id_base;
						r.addr = s.addr + 8'd1;
						r.flags[F_CLRMUTE] = 1'b1;
					end
					r = next_send(r, rd);
				end
			end
			PS_RD_DATA: r = next_send(r, rd);
			default: r.phase = PH_IDLE;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/single_wire_bus_slave.sv
// Single-wire bus slave: slot sequencer, byte store and result queue.
// A result passes through s2_q and then the result queue before it shows on m_tvalid.
// A new slot is not taken until the store read between the slot update and
// the byte handling is through, nor while the result queue is full.
// Results queue in a two-entry buffer, so slots keep flowing while one waits.
// Reset (arst_n low, asynchronous) idles the sequencer, empties the queue
// and clears unique_id; the byte store keeps its contents.
module single_wire_bus_slave #(
	parameter int STORE_DEPTH = 64,
	parameter int IDENT_BYTES = 4,
	parameter int IDENT_BASE  = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] line_sample, [7:1] zero
	input  logic        s_tuser,   // [0] op (1 = reset pulse)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] drive_low_next, [1] bus_active,
	                               // [2] enumerated, [10:3] bus_address, [15:11] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // unique_id
);
	logic          in_fire;
	logic          busy;
	logic          res_valid;
	swb_pkg::res_t res;
	logic          rd_en;
	logic [7:0]    rd_addr;
	logic          wr_en;
	logic [7:0]    wr_addr;
	logic [7:0]    wr_data;
	logic [7:0]    rd_byte;
	logic [31:0]   unique_id_q;

	// result queue
	swb_pkg::res_t q0_q;
	swb_pkg::res_t q1_q;
	logic [1:0]    cnt_q;
	logic          pop;

	// one slot in flight; room must remain in the queue for its result
	assign s_tready = !busy && cnt_q != 2'd2;
	assign in_fire  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			unique_id_q <= 32'd0;
		else if (cfg_valid && cfg_ready)
			unique_id_q <= cfg_data;
	end

	swb_ctrl #(
		.IDENT_BYTES(IDENT_BYTES),
		.IDENT_BASE (IDENT_BASE)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.op         (s_tuser),
		.line_sample(s_tdata[0]),
		.rd_byte    (rd_byte),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.busy       (busy),
		.res_valid  (res_valid),
		.res        (res)
	);

	swb_store #(
		.STORE_DEPTH(STORE_DEPTH),
		.IDENT_BYTES(IDENT_BYTES),
		.IDENT_BASE (IDENT_BASE)
	) u_store (
		.clk      (clk),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.unique_id(unique_id_q),
		.rd_byte  (rd_byte)
	);

	assign pop = m_tvalid && m_tready;

	// payload moves; head is q0
	always_ff @(posedge clk) begin
		if (pop && res_valid) begin
			if (cnt_q == 2'd1)
				q0_q <= res;
			else begin
				q0_q <= q1_q;
				q1_q <= res;
			end
		end else if (pop) begin
			q0_q <= q1_q;
		end else if (res_valid) begin
			if (cnt_q == 2'd0)
				q0_q <= res;
			else
				q1_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else if (pop && !res_valid)
			cnt_q <= cnt_q - 2'd1;
		else if (res_valid && !pop)
			cnt_q <= cnt_q + 2'd1;
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {5'd0, q0_q.bus_address, q0_q.enumerated, q0_q.bus_active,
		q0_q.drive_low_next};
endmodule

// File: hdl/swb_store.sv
// Byte store: synchronous memory plus identity bytes and out-of-range fill.
module swb_store #(
	parameter int STORE_DEPTH = 64,
	parameter int IDENT_BYTES = 4,
	parameter int IDENT_BASE  = 0
) (
	input  logic        clk,
	input  logic        rd_en,
	input  logic [7:0]  rd_addr,
	input  logic        wr_en,
	input  logic [7:0]  wr_addr,
	input  logic [7:0]  wr_data,
	input  logic [31:0] unique_id,
	output logic [7:0]  rd_byte
);
	localparam int AW = $clog2(STORE_DEPTH);

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rdata_q;
	logic [7:0] raddr_q;
	logic [8:0] rd_off;
	logic [8:0] wr_off;
	logic       wr_ok;

	assign wr_off = {1'b0, wr_addr} - 9'(IDENT_BASE);
	assign wr_ok  = !(wr_off < 9'(IDENT_BYTES)) && ({1'b0, wr_addr} < 9'(STORE_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en && wr_ok)
			mem[wr_addr[AW-1:0]] <= wr_data;
		if (rd_en) begin
			rdata_q <= mem[rd_addr[AW-1:0]];
			raddr_q <= rd_addr;
		end
	end

	assign rd_off = {1'b0, raddr_q} - 9'(IDENT_BASE);

	always_comb begin
		if (rd_off < 9'(IDENT_BYTES)) begin
			if (rd_off[2])
				rd_byte = 8'd0;
			else
				rd_byte = unique_id[{rd_off[1:0], 3'b000} +: 8];
		end else if ({1'b0, raddr_q} < 9'(STORE_DEPTH)) begin
			rd_byte = rdata_q;
		end else begin
			rd_byte = swb_pkg::BYTE_BLANK;
		end
	end
endmodule

// File: hdl/swb_ctrl.sv
// Slot sequencer: slot update on accept, byte handling after the store read.
module swb_ctrl #(
	parameter int IDENT_BYTES = 4,
	parameter int IDENT_BASE  = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          op,
	input  logic          line_sample,
	input  logic [7:0]    rd_byte,
	output logic          rd_en,
	output logic [7:0]    rd_addr,
	output logic          wr_en,
	output logic [7:0]    wr_addr,
	output logic [7:0]    wr_data,
	output logic          busy,
	output logic          res_valid,
	output swb_pkg::res_t res
);
	localparam logic [7:0] ID_BASE = 8'(IDENT_BASE);
	localparam logic [7:0] ID_END  = 8'(IDENT_BASE + IDENT_BYTES);

	swb_pkg::st_t st_q;
	swb_pkg::st_t slot_nxt;
	swb_pkg::st_t done_nxt;
	logic         s2_q;

	// slot update or reset pulse
	always_comb begin
		slot_nxt = st_q;
		if (op) begin
			slot_nxt.ps    = swb_pkg::PS_RX_ADDR;
			slot_nxt.phase = swb_pkg::PH_RECV;
			slot_nxt.shift = 8'd0;
			slot_nxt.mask  = swb_pkg::MASK_MSB;
			slot_nxt.flags = st_q.flags & (7'd1 << swb_pkg::F_ENUM);
		end else begin
			slot_nxt = swb_pkg::slot(st_q, line_sample);
		end
	end

	// store address the byte handling will read
	always_comb begin
		case (slot_nxt.ps)
			swb_pkg::PS_RX_ADDR: rd_addr = ID_BASE;
			swb_pkg::PS_RD_ADDR: rd_addr = slot_nxt.shift;
			swb_pkg::PS_ENUM:    rd_addr = (slot_nxt.ptr == ID_END) ? ID_BASE : slot_nxt.ptr;
			default:             rd_addr = slot_nxt.ptr;
		endcase
	end
	assign rd_en = in_fire;

	// up to two byte-handling passes with the read data
	always_comb begin
		done_nxt = st_q;
		if (done_nxt.phase == swb_pkg::PH_STALL)
			done_nxt = swb_pkg::byte_done(done_nxt, rd_byte, ID_BASE, ID_END);
		if (done_nxt.phase == swb_pkg::PH_STALL)
			done_nxt = swb_pkg::byte_done(done_nxt, rd_byte, ID_BASE, ID_END);
		if (done_nxt.phase == swb_pkg::PH_STALL)
			done_nxt.phase = swb_pkg::PH_IDLE;
	end

	assign wr_en   = s2_q && st_q.phase == swb_pkg::PH_STALL && st_q.ps == swb_pkg::PS_WR_DATA;
	assign wr_addr = st_q.ptr;
	assign wr_data = st_q.shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase <= swb_pkg::PH_IDLE;
			st_q.ps    <= swb_pkg::PS_IDLE;
			st_q.shift <= 8'd0;
			st_q.mask  <= swb_pkg::MASK_MSB;
			st_q.ptr   <= 8'd0;
			st_q.addr  <= swb_pkg::ADDR_NONE;
			st_q.flags <= 7'd0;
			s2_q       <= 1'b0;
		end else begin
			s2_q <= in_fire;
			if (in_fire)
				st_q <= slot_nxt;
			else if (s2_q)
				st_q <= done_nxt;
		end
	end

	assign busy      = s2_q;
	assign res_valid = s2_q;
	assign res.drive_low_next = (done_nxt.phase == swb_pkg::PH_SEND_LOW ||
		done_nxt.phase == swb_pkg::PH_ACK1 || done_nxt.phase == swb_pkg::PH_NACK2) &&
		!(done_nxt.flags[swb_pkg::F_MUTE] && swb_pkg::mutable(done_nxt.phase));
	assign res.bus_active  = done_nxt.phase != swb_pkg::PH_IDLE;
	assign res.enumerated  = done_nxt.flags[swb_pkg::F_ENUM];
	assign res.bus_address = done_nxt.addr;
endmodule

// File: hdl/swb_checker.sv
// Port-level checker for the single-wire bus slave, bound to the top level.
`include "single_wire_bus_slave_assert.svh"

module swb_port_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	`SWB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`SWB_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
	`SWB_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	`SWB_ASSERT_LATER(a_result_due, s_tvalid && s_tready, m_tvalid)
endmodule

bind single_wire_bus_slave swb_port_props u_swb_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// File: bench/swb_checker.sv
// Slot predictor and result scoreboard for the single-wire bus slave.
`timescale 1ns / 1ps
module swb_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic       drive;
		logic       active;
		logic       enum_done;
		logic [7:0] addr;
	} wire_res_t;

	wire_res_t due_q[$];

	// predicted slave state
	swb_pkg::phase_t phase;
	swb_pkg::proto_t proto;
	logic [7:0]  shreg, bmask, ptr, my_addr;
	logic        f_mute, f_par, f_enum, f_check, f_send, f_idle, f_clrmute;
	logic [31:0] ident;
	logic [7:0]  mem [64];

	function automatic logic sending(swb_pkg::phase_t p);
		return p inside {swb_pkg::PH_SEND_HIGH, swb_pkg::PH_SEND_LOW,
			swb_pkg::PH_SEND_CHECK, swb_pkg::PH_ACK1, swb_pkg::PH_ACK2,
			swb_pkg::PH_NACK1, swb_pkg::PH_NACK2};
	endfunction

	function automatic logic [7:0] fetch(logic [7:0] a);
		if (a < 8'd4)
			return ident[8*a +: 8];
		if (a < 8'd64)
			return mem[a[5:0]];
		return swb_pkg::BYTE_BLANK;
	endfunction

	task automatic shift_out_bit();
		logic v;
		v = (bmask != 8'd0) ? |(shreg & bmask) : f_par;
		if (!v) begin
			phase = swb_pkg::PH_SEND_LOW;
		end else begin
			phase = f_check ? swb_pkg::PH_SEND_CHECK : swb_pkg::PH_SEND_HIGH;
			f_par = ~f_par;
		end
	endtask

	task automatic take_slot(logic hi);
		logic muted;
		muted = f_mute && sending(phase);
		case (phase)
			swb_pkg::PH_RECV: begin
				if (hi) begin
					shreg = shreg | bmask;
					f_par = ~f_par;
				end
				if (bmask != 8'd0) begin
					bmask = bmask >> 1;
				end else if (f_par) begin
					phase = swb_pkg::PH_READY;
					f_idle = 1'b1;
				end else begin
					phase = swb_pkg::PH_STALL;
				end
			end
			swb_pkg::PH_SEND_HIGH, swb_pkg::PH_SEND_LOW, swb_pkg::PH_SEND_CHECK: begin
				if (phase == swb_pkg::PH_SEND_CHECK && !muted && !hi)
					f_mute = 1'b1;
				if (bmask == 8'd0) begin
					phase = swb_pkg::PH_STALL;
				end else begin
					bmask = bmask >> 1;
					shift_out_bit();
				end
			end
			swb_pkg::PH_ACK1: phase = swb_pkg::PH_ACK2;
			swb_pkg::PH_NACK1: phase = swb_pkg::PH_NACK2;
			swb_pkg::PH_ACK2, swb_pkg::PH_NACK2: begin
				f_par = 1'b0;
				bmask = swb_pkg::MASK_MSB;
				if (f_clrmute) begin
					f_mute = 1'b0;
					f_clrmute = 1'b0;
				end
				if (f_idle) begin
					phase = swb_pkg::PH_IDLE;
				end else if (f_send) begin
					shift_out_bit();
				end else begin
					phase = swb_pkg::PH_RECV;
					shreg = 8'd0;
				end
			end
			swb_pkg::PH_READY: begin
				if (hi)
					phase = f_par ? swb_pkg::PH_NACK1 : swb_pkg::PH_ACK1;
			end
			swb_pkg::PH_STALL: ;
			default: phase = swb_pkg::PH_IDLE;
		endcase
	endtask

	task automatic load_tx_byte();
		if (!f_mute || f_clrmute)
			shreg = fetch(ptr);
		ptr = ptr + 8'd1;
		phase = swb_pkg::PH_READY;
	endtask

	// protocol step after a complete byte
	task automatic finish_byte();
		case (proto)
			swb_pkg::PS_RX_ADDR: begin
				if (shreg == swb_pkg::CODE_ENUMERATE) begin
					proto = swb_pkg::PS_ENUM;
					f_check = 1'b1;
					f_send = 1'b1;
					f_enum = 1'b0;
					ptr = 8'd0;
					my_addr = 8'd0;
				end else if (f_enum && shreg == my_addr) begin
					phase = swb_pkg::PH_READY;
					proto = swb_pkg::PS_RX_CMD;
				end else begin
					phase = swb_pkg::PH_IDLE;
				end
			end
			swb_pkg::PS_RX_CMD: begin
				if (shreg == swb_pkg::CMD_READ) begin
					proto = swb_pkg::PS_RD_ADDR;
					phase = swb_pkg::PH_READY;
				end else if (shreg == swb_pkg::CMD_WRITE) begin
					proto = swb_pkg::PS_WR_ADDR;
					phase = swb_pkg::PH_READY;
				end else begin
					phase = swb_pkg::PH_IDLE;
				end
			end
			swb_pkg::PS_RD_ADDR: begin
				ptr = shreg;
				f_send = 1'b1;
				proto = swb_pkg::PS_RD_DATA;
			end
			swb_pkg::PS_WR_ADDR: begin
				ptr = shreg;
				proto = swb_pkg::PS_WR_DATA;
				phase = swb_pkg::PH_READY;
			end
			swb_pkg::PS_WR_DATA: begin
				if (ptr >= 8'd4 && ptr < 8'd64)
					mem[ptr[5:0]] = shreg;
				ptr = ptr + 8'd1;
				phase = swb_pkg::PH_READY;
			end
			swb_pkg::PS_ENUM: begin
				if (ptr == 8'd4 && !f_mute) begin
					proto = swb_pkg::PS_IDLE;
					f_idle = 1'b1;
					f_enum = 1'b1;
					phase = swb_pkg::PH_READY;
				end else begin
					if (ptr == 8'd4) begin
						// lost arbitration: next address, resend the ID
						ptr = 8'd0;
						my_addr = my_addr + 8'd1;
						f_clrmute = 1'b1;
					end
					load_tx_byte();
				end
			end
			swb_pkg::PS_RD_DATA: load_tx_byte();
			default: phase = swb_pkg::PH_IDLE;
		endcase
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		wire_res_t w;
		if (!arst_n) begin
			phase = swb_pkg::PH_IDLE;
			proto = swb_pkg::PS_IDLE;
			shreg = 8'd0;
			bmask = swb_pkg::MASK_MSB;
			ptr = 8'd0;
			my_addr = swb_pkg::ADDR_NONE;
			{f_mute, f_par, f_enum, f_check, f_send, f_idle, f_clrmute} = '0;
			ident = 32'd0;
			errors = 0;
			due_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				ident = cfg_data;
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					w = due_q.pop_front();
					check_field("drive_low_next", 8'(w.drive), 8'(m_tdata[0]));
					check_field("bus_active", 8'(w.active), 8'(m_tdata[1]));
					check_field("enumerated", 8'(w.enum_done), 8'(m_tdata[2]));
					check_field("bus_address", w.addr, m_tdata[10:3]);
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					proto = swb_pkg::PS_RX_ADDR;
					phase = swb_pkg::PH_RECV;
					shreg = 8'd0;
					bmask = swb_pkg::MASK_MSB;
					{f_mute, f_par, f_check, f_send, f_idle, f_clrmute} = '0;
				end else begin
					take_slot(s_tdata[0]);
					for (int k = 0; k < 2 && phase == swb_pkg::PH_STALL; k++)
						finish_byte();
					if (phase == swb_pkg::PH_STALL)
						phase = swb_pkg::PH_IDLE;
				end
				w.drive = (phase inside {swb_pkg::PH_SEND_LOW, swb_pkg::PH_ACK1,
					swb_pkg::PH_NACK2, swb_pkg::PH_STALL}) && !(f_mute && sending(phase));
				w.active = (phase != swb_pkg::PH_IDLE);
				w.enum_done = f_enum;
				w.addr = my_addr;
				due_q.push_back(w);
			end
		end
		pending = due_q.size();
	end

endmodule

// File: bench/tb.sv
// Top of the single-wire bus slave bench: bus traffic, idling and verdict.
`timescale 1ns / 1ps
module tb;

	localparam int N_ITEMS = 850;
	localparam int LIMIT   = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] line_sample, [7:1] zero
	logic        s_tuser = 1'b0;   // [0] op, 1 = reset pulse
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [0] drive_low_next, [1] bus_active,
	                               // [2] enumerated, [10:3] bus_address
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'd0;
	int          errors, pending;

	int          send_pct, recv_pct;   // idle percentages of each side
	int          n_items;
	logic [31:0] cur_id;
	logic [7:0]  node_addr;            // address the slave claimed
	bit          claimed;
	bit          written [64];         // store entries given a value

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	single_wire_bus_slave u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	swb_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	// receiver back-pressure, rerolled every cycle
	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_pct);

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	// one slot transfer; called and returns at a falling edge
	task automatic put_slot(input logic pulse, input logic line);
		while ($urandom_range(0, 99) < send_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= pulse;
		s_tdata <= {7'd0, line};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		n_items++;
	endtask

	task automatic bus_reset();
		put_slot(1'b1, 1'($urandom_range(0, 1)));
	endtask

	// ready bit (line may be held low a while), then the two ACK/NACK slots
	task automatic close_byte();
		repeat ($urandom_range(0, 2)) put_slot(1'b0, 1'b0);
		put_slot(1'b0, 1'b1);
		put_slot(1'b0, 1'($urandom_range(0, 1)));
		put_slot(1'b0, 1'($urandom_range(0, 1)));
	endtask

	// master sends a byte, MSB first, even parity unless spoiled
	task automatic host_byte(input logic [7:0] b, input bit spoil);
		logic [8:0] v;
		v = {b, ^b ^ spoil};
		for (int i = 8; i >= 0; i--)
			put_slot(1'b0, v[i]);
		close_byte();
	endtask

	// slave sends a byte; line samples are don't-care outside enumeration
	task automatic slave_byte();
		repeat (9) put_slot(1'b0, 1'($urandom_range(0, 1)));
		close_byte();
	endtask

	// enumeration; other nodes pull the line low now and then in early rounds
	task automatic enumerate();
		int round;
		bit lost, low;
		logic [8:0] v;
		round = 0;
		bus_reset();
		host_byte(swb_pkg::CODE_ENUMERATE, 1'b0);
		forever begin
			lost = 1'b0;
			for (int k = 0; k < 4; k++) begin
				v = {cur_id[8*k +: 8], ^cur_id[8*k +: 8]};
				for (int i = 8; i >= 0; i--) begin
					low = round < 2 && v[i] && $urandom_range(0, 11) == 0;
					lost |= low;
					put_slot(1'b0, v[i] & !low);
				end
				close_byte();
			end
			if (!lost)
				break;
			round++;
		end
		node_addr = 8'(round);
		claimed = 1'b1;
	endtask

	task automatic write_txn();
		logic [7:0] a;
		a = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(4, 63)) : 8'($urandom);
		bus_reset();
		host_byte(node_addr, 1'b0);
		host_byte(swb_pkg::CMD_WRITE, 1'b0);
		host_byte(a, 1'b0);
		repeat ($urandom_range(1, 4)) begin
			host_byte(8'($urandom), 1'b0);
			if (a >= 8'd4 && a < 8'd64)
				written[a[5:0]] = 1'b1;
			a++;
		end
	endtask

	function automatic bit readable(int a);
		if (a < 4 || a >= 64)
			return 1'b1;
		return written[a[5:0]];
	endfunction

	// the slave prefetches one byte past the last one sent, so the span
	// covers n+1 addresses, all of them ID, written or out of range
	task automatic read_txn();
		int a, n;
		bit ok;
		n = $urandom_range(1, 3);
		ok = 1'b0;
		for (int t = 0; t < 8 && !ok; t++) begin
			a = $urandom_range(0, 63);
			ok = 1'b1;
			for (int j = 0; j <= n; j++)
				ok &= readable(a + j);
		end
		if (!ok)
			a = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(64, 252);
		bus_reset();
		host_byte(node_addr, 1'b0);
		host_byte(swb_pkg::CMD_READ, 1'b0);
		host_byte(a[7:0], 1'b0);
		repeat (n) slave_byte();
	endtask

	task automatic foreign_txn();
		logic [7:0] b;
		do b = 8'($urandom); while (b == node_addr || b == swb_pkg::CODE_ENUMERATE);
		bus_reset();
		host_byte(b, 1'b0);
		host_byte(8'($urandom), 1'b0);
	endtask

	task automatic bad_cmd_txn();
		logic [7:0] c;
		do c = 8'($urandom); while (c == swb_pkg::CMD_READ || c == swb_pkg::CMD_WRITE);
		bus_reset();
		host_byte(node_addr, 1'b0);
		host_byte(c, 1'b0);
	endtask

	// short bursts of random slots and reset pulses after a bus reset
	task automatic noise();
		bus_reset();
		repeat ($urandom_range(1, 24))
			put_slot($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
	endtask

	// drain every expected result, let the pipe settle, then write the ID
	task automatic set_ident(input logic [31:0] v);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_id = v;
	endtask

	initial begin
		n_items = 0;
		claimed = 1'b0;
		node_addr = swb_pkg::ADDR_NONE;
		send_pct = 27;
		recv_pct = 56;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_pct = 27;
					recv_pct = 56;
				end
				1: begin
					send_pct = 56;
					recv_pct = 27;
				end
				default: begin
					send_pct = 0;
					recv_pct = 0;
				end
			endcase
			set_ident(ph == 0 ? 32'hffff_ffff : ph == 1 ? 32'd0 : $urandom);
			if (ph == 0) begin
				// directed opening: slot before any reset, bad parity, then claim
				put_slot(1'b0, 1'b1);
				bus_reset();
				host_byte(8'h00, 1'b1);
				enumerate();
			end
			while (n_items < (ph + 1) * N_ITEMS / 3) begin
				if (!claimed) begin
					enumerate();
				end else begin
					case ($urandom_range(0, 9))
						0: enumerate();
						1, 2, 3: write_txn();
						4, 5, 6: read_txn();
						7: if ($urandom_range(0, 1) != 0) foreign_txn(); else bad_cmd_txn();
						8: begin
							bus_reset();
							host_byte(8'($urandom), 1'b1);
						end
						default: noise();
					endcase
				end
			end
		end

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
